FILE: rtl/core/pse_pkg.sv
// Shared types and codes of the postfix stack evaluator.
// The controller, the datapath and the top level import this package.
package pse_pkg;

    localparam int DATA_W = 32;

    // Request kinds carried in the input tuser.
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_OP   = 2'd1;
    localparam logic [1:0] REQ_FIN  = 2'd2;

    // Operator codes.
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_NEG = 4'd5;
    localparam logic [3:0] OP_NOT = 4'd6;
    localparam logic [3:0] OP_LT  = 4'd7;
    localparam logic [3:0] OP_GT  = 4'd8;
    localparam logic [3:0] OP_EQ  = 4'd9;
    localparam logic [3:0] OP_LE  = 4'd10;
    localparam logic [3:0] OP_GE  = 4'd11;
    localparam logic [3:0] OP_NE  = 4'd12;
    localparam logic [3:0] OP_AND = 4'd13;
    localparam logic [3:0] OP_OR  = 4'd14;

    // Status codes reported with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    // Datapath actions issued by the controller.
    typedef enum logic [3:0] {
        A_NONE,
        A_PUSH,
        A_UNARY,
        A_FAULT,
        A_NOPRES,
        A_READ,
        A_BIN,
        A_DIVSTART,
        A_DIVDONE,
        A_FIN,
        A_RELOAD
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [1:0] fault;
        logic [3:0] op;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt2;
        logic full;
        logic top_zero;
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic signed [DATA_W-1:0] top;
        logic [4:0]               depth;
        logic [1:0]               status;
        logic                     fin;
    } t_result;

endpackage

FILE: rtl/core/pse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pse_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/pse_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Truncates toward zero; the remainder takes the sign of the dividend. No dependencies.
module pse_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_dividend,
    input  logic signed [31:0] i_divisor,
    output logic               o_done,
    output logic signed [31:0] o_quotient,
    output logic signed [31:0] o_remainder
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_step;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic        r_neg_q;
    logic        r_neg_r;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        take;

    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_den};
    assign take    = !diff[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 5'd1;
                if (r_step == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operands are held as magnitudes; signs are applied on the way out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo   <= i_dividend[31] ? 32'd0 - i_dividend : i_dividend;
            r_den   <= i_divisor[31] ? 32'd0 - i_divisor : i_divisor;
            r_rem   <= '0;
            r_neg_q <= i_dividend[31] ^ i_divisor[31];
            r_neg_r <= i_dividend[31];
        end else if (r_busy) begin
            r_rem <= take ? diff[31:0] : shifted[31:0];
            r_quo <= {r_quo[30:0], take};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? 32'd0 - r_quo : r_quo;
    assign o_remainder = r_neg_r ? 32'd0 - r_rem : r_rem;

endmodule

FILE: rtl/core/pse_datapath.sv
// Evaluator datapath: cached top of stack, stack RAM below it, ALU and divider.
// Uses pse_pkg, pse_ram and pse_div; driven by commands from pse_ctrl.
module pse_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pse_pkg::t_cmd        i_cmd,
    input  logic signed [31:0]   i_literal,
    output pse_pkg::t_stat       o_stat,
    output pse_pkg::t_result     o_res
);
    import pse_pkg::*;

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

    // The top entry lives in r_top; entries below it live in the RAM at
    // addresses 0 .. count-2.
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic signed [31:0]  r_top;
    logic signed [31:0]  n_top;
    logic signed [31:0]  r_res_top;
    logic signed [31:0]  n_res_top;
    logic [1:0]          r_res_status;
    logic [1:0]          n_res_status;
    logic                r_res_fin;
    logic                n_res_fin;

    logic [COUNT_W-1:0]  count_m1;
    logic [COUNT_W-1:0]  count_m2;
    logic [COUNT_W+4:0]  count_ext;
    logic signed [31:0]  top_or_zero;

    logic                ram_wr_en;
    logic                ram_rd_en;
    logic signed [31:0]  ram_rd_data;

    logic signed [31:0]  opa;
    logic signed [31:0]  opb;
    logic signed [31:0]  prod;
    logic signed [31:0]  bin_res;
    logic signed [31:0]  un_res;

    logic                div_done;
    logic signed [31:0]  div_quo;
    logic signed [31:0]  div_rem;

    assign count_m1    = r_count - COUNT_W'(1);
    assign count_m2    = r_count - COUNT_W'(2);
    assign count_ext   = {5'd0, r_count};
    assign top_or_zero = (r_count == '0) ? 32'sd0 : r_top;

    assign ram_wr_en = (i_cmd.act == A_PUSH) && (r_count != '0);
    assign ram_rd_en = (i_cmd.act == A_READ) || (i_cmd.act == A_FIN);

    pse_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (count_m1[ADDR_W-1:0]),
        .i_wr_data (r_top),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (count_m2[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    pse_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.act == A_DIVSTART),
        .i_dividend  (ram_rd_data),
        .i_divisor   (r_top),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Left operand comes from the RAM read, right operand is the cached top.
    assign opa  = ram_rd_data;
    assign opb  = r_top;
    assign prod = opa * opb;

    always_comb begin
        case (i_cmd.op)
            OP_ADD:  bin_res = opa + opb;
            OP_SUB:  bin_res = opa - opb;
            OP_MUL:  bin_res = prod;
            OP_LT:   bin_res = {31'd0, opa < opb};
            OP_GT:   bin_res = {31'd0, opa > opb};
            OP_EQ:   bin_res = {31'd0, opa == opb};
            OP_LE:   bin_res = {31'd0, opa <= opb};
            OP_GE:   bin_res = {31'd0, opa >= opb};
            OP_NE:   bin_res = {31'd0, opa != opb};
            OP_AND:  bin_res = {31'd0, (opa != 32'sd0) && (opb != 32'sd0)};
            OP_OR:   bin_res = {31'd0, (opa != 32'sd0) || (opb != 32'sd0)};
            default: bin_res = 32'sd0;
        endcase
    end

    assign un_res = (i_cmd.op == OP_NEG) ? 32'sd0 - r_top : {31'd0, r_top == 32'sd0};

    always_comb begin
        n_count      = r_count;
        n_top        = r_top;
        n_res_top    = r_res_top;
        n_res_status = r_res_status;
        n_res_fin    = r_res_fin;
        case (i_cmd.act)
            A_PUSH: begin
                n_count      = r_count + COUNT_W'(1);
                n_top        = i_literal;
                n_res_top    = i_literal;
                n_res_status = ST_OK;
                n_res_fin    = 1'b0;
            end
            A_UNARY: begin
                n_top        = un_res;
                n_res_top    = un_res;
                n_res_status = ST_OK;
                n_res_fin    = 1'b0;
            end
            A_FAULT: begin
                n_res_top    = top_or_zero;
                n_res_status = i_cmd.fault;
                n_res_fin    = 1'b0;
            end
            A_NOPRES: begin
                n_res_top    = top_or_zero;
                n_res_status = ST_OK;
                n_res_fin    = 1'b0;
            end
            A_BIN: begin
                n_count      = count_m1;
                n_top        = bin_res;
                n_res_top    = bin_res;
                n_res_status = ST_OK;
                n_res_fin    = 1'b0;
            end
            A_DIVDONE: begin
                n_count      = count_m1;
                n_top        = (i_cmd.op == OP_MOD) ? div_rem : div_quo;
                n_res_top    = (i_cmd.op == OP_MOD) ? div_rem : div_quo;
                n_res_status = ST_OK;
                n_res_fin    = 1'b0;
            end
            A_FIN: begin
                n_count      = count_m1;
                n_res_top    = r_top;
                n_res_status = ST_OK;
                n_res_fin    = 1'b1;
            end
            A_RELOAD: begin
                n_top = ram_rd_data;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_res_top    <= n_res_top;
        r_res_status <= n_res_status;
        r_res_fin    <= n_res_fin;
    end

    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.cnt_lt2  = (r_count < COUNT_W'(2));
    assign o_stat.full     = (r_count >= COUNT_W'(STACK_DEPTH));
    assign o_stat.top_zero = (r_top == 32'sd0);
    assign o_stat.div_done = div_done;

    assign o_res.top    = r_res_top;
    assign o_res.depth  = count_ext[4:0];
    assign o_res.status = r_res_status;
    assign o_res.fin    = r_res_fin;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(STACK_DEPTH))
        else $error("stack count exceeds the stack depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == A_PUSH) |-> !o_stat.full)
        else $error("push issued on a full stack");

endmodule

FILE: rtl/core/pse_ctrl.sv
// Evaluator controller: decodes each request and sequences the datapath.
// Uses pse_pkg; drives pse_datapath through t_cmd and reads t_stat back.
module pse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_req,
    input  logic [3:0]     i_op,
    input  pse_pkg::t_stat i_stat,
    input  logic           i_out_free,
    output pse_pkg::t_cmd  o_cmd
);
    import pse_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_BIN    = 5'b00010,
        S_DIV    = 5'b00100,
        S_RELOAD = 5'b01000,
        S_HOLD   = 5'b10000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [3:0] r_op;
    logic [3:0] n_op;
    logic       in_div_op;
    logic       op_is_div;

    assign in_div_op = (i_op == OP_DIV) || (i_op == OP_MOD);
    assign op_is_div = (r_op == OP_DIV) || (r_op == OP_MOD);
    assign o_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        o_cmd.act   = A_NONE;
        o_cmd.fault = ST_OK;
        o_cmd.op    = r_op;
        o_cmd.emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.op = i_op;
                if (i_valid) begin
                    n_op    = i_op;
                    n_state = S_HOLD;
                    case (i_req)
                        REQ_PUSH: begin
                            if (i_stat.full) begin
                                o_cmd.act   = A_FAULT;
                                o_cmd.fault = ST_OVER;
                            end else begin
                                o_cmd.act = A_PUSH;
                            end
                        end
                        REQ_OP: begin
                            if (i_op == OP_NEG || i_op == OP_NOT) begin
                                if (i_stat.cnt_zero) begin
                                    o_cmd.act   = A_FAULT;
                                    o_cmd.fault = ST_UNDER;
                                end else begin
                                    o_cmd.act = A_UNARY;
                                end
                            end else if (i_op > OP_OR) begin
                                o_cmd.act = A_NOPRES;
                            end else if (i_stat.cnt_lt2) begin
                                o_cmd.act   = A_FAULT;
                                o_cmd.fault = ST_UNDER;
                            end else if (in_div_op && i_stat.top_zero) begin
                                o_cmd.act   = A_FAULT;
                                o_cmd.fault = ST_DIVZ;
                            end else begin
                                o_cmd.act = A_READ;
                                n_state   = S_BIN;
                            end
                        end
                        REQ_FIN: begin
                            if (i_stat.cnt_zero) begin
                                o_cmd.act   = A_FAULT;
                                o_cmd.fault = ST_UNDER;
                            end else begin
                                // The entry below the popped top must be fetched.
                                o_cmd.act = A_FIN;
                                n_state   = i_stat.cnt_lt2 ? S_HOLD : S_RELOAD;
                            end
                        end
                        default: begin
                            o_cmd.act = A_NOPRES;
                        end
                    endcase
                end
            end
            S_BIN: begin
                if (op_is_div) begin
                    o_cmd.act = A_DIVSTART;
                    n_state   = S_DIV;
                end else begin
                    o_cmd.act = A_BIN;
                    n_state   = S_HOLD;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.act = A_DIVDONE;
                    n_state   = S_HOLD;
                end
            end
            S_RELOAD: begin
                o_cmd.act = A_RELOAD;
                n_state   = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start a step");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

endmodule

FILE: rtl/core/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: stream ports and output register.
// Uses pse_pkg, pse_ctrl and pse_datapath.
//
// The block takes one request per input transaction (push a literal, apply an
// operator, or finish and pop the result) and returns exactly one result
// transaction for it, carrying the new top of stack, the depth and a status;
// tlast marks a finished expression value. Requests are handled one at a
// time. For push, unary operators, faults, unknown codes and a finish that
// empties the stack, the datapath registers the result at acceptance and the
// hold state then loads it into the output register. Binary operators other
// than divide and modulo, and a finish that leaves one or more entries, pass
// through S_BIN or S_RELOAD first because the entry below the top is read from
// the stack RAM, which has a registered read port. Divide and modulo also wait
// in S_DIV for the radix-2 divider, which produces one quotient bit per cycle.
// A result that finds the output register still occupied waits until the
// receiver takes the previous one. The stack holds STACK_DEPTH entries, the
// top one in a register and the rest in the RAM; stack entries are not cleared
// at reset and need no clearing pass. A new request is accepted while the
// previous result still waits in the output register.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // literal[31:0], op_code[35:32], zero[39:36]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // top_value[31:0], depth[36:32], status[38:37], zero[39]
    output logic        m_axis_tlast   // is_final
);
    import pse_pkg::*;

    t_cmd        cmd;
    t_stat       stat;
    t_result     res;
    logic        out_free;
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_out_last;

    assign out_free = !r_out_valid || m_axis_tready;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req      (s_axis_tuser),
        .i_op       (s_axis_tdata[35:32]),
        .i_stat     (stat),
        .i_out_free (out_free),
        .o_cmd      (cmd)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_literal (s_axis_tdata[31:0]),
        .o_stat    (stat),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out_data <= {1'b0, res.status, res.depth, res.top};
            r_out_last <= res.fin;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: sim/tb_postfix_stack_evaluator.sv
// Self-checking testbench for the postfix stack evaluator: directed and random token streams.
// Depends on pse_pkg and postfix_stack_evaluator; the expected results come from a
// stack model kept inside this file.
module tb_postfix_stack_evaluator;
    import pse_pkg::*;

    localparam int STACK_N     = 16;
    localparam int TOKEN_GOAL  = 1050;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_WAIT  = 60;

    // Codes that the block must treat as no-ops.
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [3:0] OP_NONE  = 4'd15;

    // Receiver back-pressure patterns.
    localparam logic [1:0] STALL_NONE   = 2'd0;
    localparam logic [1:0] STALL_COIN   = 2'd1;
    localparam logic [1:0] STALL_HEAVY  = 2'd2;
    localparam logic [1:0] STALL_CYCLIC = 2'd3;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] lit;
        logic [3:0]  op;
        bit          hold_idle;  // wait for all results before sending
    } t_rpn_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // literal[31:0], op_code[35:32], zero[39:36]
    logic [1:0]  s_axis_tuser = '0;  // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // top_value[31:0], depth[36:32], status[38:37], zero[39]
    logic        m_axis_tlast;       // is_final

    t_rpn_token  token_q[$];
    t_result     answer_q[$];
    t_rpn_token  cur_tok;

    logic [31:0] stk_mem[STACK_N];
    int          stk_cnt = 0;

    int n_tokens   = 0;
    int n_useful   = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int n_cycles   = 0;

    int         burst_left = 0;
    int         gap_left   = 0;
    logic [1:0] stall_mode = STALL_NONE;
    int         stall_left = 0;
    int         stall_tick = 0;

    logic [3:0] bin_ops[13] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT,
                                OP_EQ, OP_LE, OP_GE, OP_NE, OP_AND, OP_OR};

    postfix_stack_evaluator #(.STACK_DEPTH(STACK_N)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Applies one token to the stack model and returns the result it must produce.
    function automatic t_result eval_token(t_rpn_token t);
        t_result     r;
        logic [31:0] a, b, v;
        longint      sa, sb, q;
        r.top    = '0;
        r.status = ST_OK;
        r.fin    = 1'b0;
        case (t.req)
            REQ_PUSH: begin
                if (stk_cnt >= STACK_N) begin
                    r.status = ST_OVER;
                end else begin
                    stk_mem[stk_cnt] = t.lit;
                    stk_cnt++;
                end
            end
            REQ_OP: begin
                if (t.op == OP_NEG || t.op == OP_NOT) begin
                    if (stk_cnt < 1) begin
                        r.status = ST_UNDER;
                    end else begin
                        b = stk_mem[stk_cnt-1];
                        stk_mem[stk_cnt-1] = (t.op == OP_NEG) ? 32'd0 - b : {31'd0, b == 32'd0};
                    end
                end else if (t.op != OP_NONE) begin
                    if (stk_cnt < 2) begin
                        r.status = ST_UNDER;
                    end else begin
                        b  = stk_mem[stk_cnt-1];
                        a  = stk_mem[stk_cnt-2];
                        sa = longint'(signed'(a));
                        sb = longint'(signed'(b));
                        if ((t.op == OP_DIV || t.op == OP_MOD) && b == 32'd0) begin
                            r.status = ST_DIVZ;
                        end else begin
                            // 64-bit signed arithmetic makes the most negative value
                            // divided by -1 wrap back to itself once truncated.
                            q = 0;
                            case (t.op)
                                OP_ADD: v = a + b;
                                OP_SUB: v = a - b;
                                OP_MUL: v = a * b;
                                OP_DIV: begin
                                    q = sa / sb;
                                    v = q[31:0];
                                end
                                OP_MOD: begin
                                    q = sa % sb;
                                    v = q[31:0];
                                end
                                OP_LT:  v = {31'd0, sa < sb};
                                OP_GT:  v = {31'd0, sa > sb};
                                OP_EQ:  v = {31'd0, a == b};
                                OP_LE:  v = {31'd0, sa <= sb};
                                OP_GE:  v = {31'd0, sa >= sb};
                                OP_NE:  v = {31'd0, a != b};
                                OP_AND: v = {31'd0, (a != 32'd0) && (b != 32'd0)};
                                default: v = {31'd0, (a != 32'd0) || (b != 32'd0)};
                            endcase
                            stk_mem[stk_cnt-2] = v;
                            stk_cnt--;
                        end
                    end
                end
            end
            REQ_FIN: begin
                if (stk_cnt < 1) begin
                    r.status = ST_UNDER;
                end else begin
                    r.top = stk_mem[stk_cnt-1];
                    stk_cnt--;
                    r.fin = 1'b1;
                end
            end
            default: ;
        endcase
        if (!r.fin)
            r.top = (stk_cnt == 0) ? 32'd0 : stk_mem[stk_cnt-1];
        r.depth = stk_cnt[4:0];
        return r;
    endfunction

    // Queues a token; the stack model runs along so that the generator knows the depth.
    task automatic add_token(logic [1:0] req, logic [31:0] lit, logic [3:0] op, bit hold);
        t_rpn_token t;
        t_result    unused;
        t.req       = req;
        t.lit       = lit;
        t.op        = op;
        t.hold_idle = hold;
        unused      = eval_token(t);
        token_q.push_back(t);
        n_tokens++;
        if (!(req == REQ_NONE || (req == REQ_OP && op == OP_NONE)))
            n_useful++;
    endtask

    function automatic logic [31:0] rand_literal();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int  kind, len, extra;
        bit  first;
        logic [31:0] corner[5];
        corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd5};

        // Directed: faults on an empty or short stack, no-op codes, divider corners.
        add_token(REQ_FIN, 32'd0, OP_ADD, 1'b0);
        add_token(REQ_OP, 32'd0, OP_ADD, 1'b0);
        add_token(REQ_OP, 32'd0, OP_NEG, 1'b0);
        add_token(REQ_NONE, 32'hFFFF_FFFF, OP_NONE, 1'b0);
        add_token(REQ_OP, 32'd0, OP_NONE, 1'b0);
        add_token(REQ_PUSH, 32'h8000_0000, OP_ADD, 1'b0);
        add_token(REQ_OP, 32'd0, OP_SUB, 1'b0);
        add_token(REQ_OP, 32'd0, OP_NEG, 1'b0);
        add_token(REQ_PUSH, 32'hFFFF_FFFF, OP_ADD, 1'b0);
        add_token(REQ_OP, 32'd0, OP_DIV, 1'b0);
        add_token(REQ_PUSH, 32'hFFFF_FFFF, OP_ADD, 1'b0);
        add_token(REQ_OP, 32'd0, OP_MOD, 1'b0);
        add_token(REQ_PUSH, 32'd0, OP_ADD, 1'b0);
        add_token(REQ_OP, 32'd0, OP_DIV, 1'b0);
        add_token(REQ_OP, 32'd0, OP_MOD, 1'b0);
        add_token(REQ_OP, 32'd0, OP_NOT, 1'b0);
        add_token(REQ_OP, 32'd0, OP_NEG, 1'b0);
        add_token(REQ_PUSH, 32'h7FFF_FFFF, OP_ADD, 1'b0);
        add_token(REQ_PUSH, 32'd1, OP_ADD, 1'b0);
        add_token(REQ_OP, 32'd0, OP_ADD, 1'b0);
        for (int i = 0; i < 13; i++) begin
            add_token(REQ_PUSH, corner[i % 5], OP_ADD, 1'b0);
            add_token(REQ_OP, 32'd0, bin_ops[(i + 2) % 13], 1'b0);
        end
        while (stk_cnt > 0)
            add_token(REQ_FIN, 32'd0, OP_ADD, 1'b0);

        // Random: mostly well-formed expressions, some overflowing, some noise.
        first = 1'b1;
        while (n_useful < TOKEN_GOAL) begin
            kind = first ? 15 : $urandom_range(0, 99);
            if (kind < 10) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    add_token(2'($urandom_range(0, 3)), $urandom(), 4'($urandom_range(0, 15)),
                              $urandom_range(0, 29) == 0);
            end else if (kind < 20) begin
                add_token(REQ_PUSH, rand_literal(), OP_ADD, first);
                while (stk_cnt < STACK_N)
                    add_token(REQ_PUSH, rand_literal(), OP_ADD, 1'b0);
                extra = $urandom_range(1, 2);
                for (int i = 0; i < extra; i++)
                    add_token(REQ_PUSH, $urandom(), 4'($urandom_range(0, 15)), 1'b0);
                while (stk_cnt > 2)
                    add_token(REQ_OP, 32'd0, bin_ops[$urandom_range(0, 12)], 1'b0);
                add_token(REQ_FIN, 32'd0, OP_ADD, 1'b0);
            end else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    if (stk_cnt < 2 || $urandom_range(0, 99) < 40)
                        add_token(REQ_PUSH, rand_literal(), OP_ADD,
                                  i == 0 && $urandom_range(0, 39) == 0);
                    else if ($urandom_range(0, 99) < 15)
                        add_token(REQ_OP, 32'd0, $urandom_range(0, 1) ? OP_NEG : OP_NOT, 1'b0);
                    else
                        add_token(REQ_OP, 32'd0, bin_ops[$urandom_range(0, 12)], 1'b0);
                end
                add_token(REQ_FIN, 32'd0, OP_ADD, 1'b0);
            end
            // Now and then empty the stack and pop once more for an underflow.
            if (stk_cnt > 6 && $urandom_range(0, 1) == 1) begin
                while (stk_cnt > 0)
                    add_token(REQ_FIN, 32'd0, OP_ADD, 1'b0);
                add_token(REQ_FIN, 32'd0, OP_ADD, 1'b0);
            end
            first = 1'b0;
        end
        stk_cnt = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_accepted == n_tokens && answer_q.size() == 0))
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Driver: sends tokens in bursts; a flagged token waits until nothing is outstanding.
    always @(posedge i_clk) begin
        logic fire;
        fire = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            if (fire) begin
                answer_q.push_back(eval_token(cur_tok));
                n_accepted++;
            end
            if (s_axis_tvalid && !fire) begin
                // The current transaction stays on the bus until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (token_q.size() > 0 &&
                         !(token_q[0].hold_idle && answer_q.size() > 0)) begin
                cur_tok = token_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'd0, cur_tok.op, cur_tok.lit};
                s_axis_tuser  <= cur_tok.req;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction and applies back-pressure.
    always @(posedge i_clk) begin
        t_result got, want;
        logic    rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.top    = m_axis_tdata[31:0];
                got.depth  = m_axis_tdata[36:32];
                got.status = m_axis_tdata[38:37];
                got.fin    = m_axis_tlast;
                if (answer_q.size() == 0) begin
                    n_errors++;
                    $error("result with no request outstanding: top_value %0d", got.top);
                end else begin
                    want = answer_q.pop_front();
                    if (got.top !== want.top) begin
                        n_errors++;
                        $error("top_value: expected %0d, actual %0d", want.top, got.top);
                    end
                    if (got.depth !== want.depth) begin
                        n_errors++;
                        $error("depth: expected %0d, actual %0d", want.depth, got.depth);
                    end
                    if (got.status !== want.status) begin
                        n_errors++;
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                    end
                    if (got.fin !== want.fin) begin
                        n_errors++;
                        $error("is_final: expected %0d, actual %0d", want.fin, got.fin);
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = 2'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 200);
            end else begin
                stall_left--;
            end
            stall_tick = (stall_tick + 1) % 5;
            case (stall_mode)
                STALL_NONE:   rdy = 1'b1;
                STALL_COIN:   rdy = 1'($urandom_range(0, 1));
                STALL_HEAVY:  rdy = ($urandom_range(0, 7) == 0);
                STALL_CYCLIC: rdy = (stall_tick < 3);
                default:      rdy = 1'b1;
            endcase
            m_axis_tready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

FILE: filelist.f
rtl/core/pse_pkg.sv
rtl/core/pse_ram.sv
rtl/core/pse_div.sv
rtl/core/pse_datapath.sv
rtl/core/pse_ctrl.sv
rtl/core/postfix_stack_evaluator.sv
sim/tb_postfix_stack_evaluator.sv
